// ===== design/ptl_pkg.sv =====
// Shared register codes, output limits and width helpers for the
// point-to-line distance block. No dependencies.
package ptl_pkg;

    localparam int CFG_IDX_BITS = 3;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ORIGIN_X = 3'd0,
        REG_ORIGIN_Y = 3'd1,
        REG_ORIGIN_Z = 3'd2,
        REG_DIR_X    = 3'd3,
        REG_DIR_Y    = 3'd4,
        REG_DIR_Z    = 3'd5
    } cfg_reg_t;

    localparam int DIST_BITS = 17;
    localparam logic [DIST_BITS-1:0] DIST_MAX = 17'h1FFFF;
    localparam int DIR_X_RESET = 256;

    localparam int FRONT_STAGES = 6;

    // magnitude of a cross product component
    function automatic int mag_width(input int c);
        return 2 * c + 1;
    endfunction

    // sum of three squared magnitudes
    function automatic int num_width(input int c);
        return 4 * c + 4;
    endfunction

    // squared length of the direction
    function automatic int div_width(input int c);
        return 2 * c;
    endfunction

    // squared distance
    function automatic int quo_width(input int c);
        return 2 * c + 2;
    endfunction

    function automatic int root_width(input int c);
        return c + 1;
    endfunction

endpackage

// ===== design/ptl_cfg.sv =====
// Line origin and direction registers.
// Depends on ptl_pkg for register codes and reset values.
module ptl_cfg #(
    parameter int COORD_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [ptl_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [COORD_BITS-1:0]                cfg_data,
    output logic signed [COORD_BITS-1:0]         origin_x,
    output logic signed [COORD_BITS-1:0]         origin_y,
    output logic signed [COORD_BITS-1:0]         origin_z,
    output logic signed [COORD_BITS-1:0]         dir_x,
    output logic signed [COORD_BITS-1:0]         dir_y,
    output logic signed [COORD_BITS-1:0]         dir_z
);

    logic [COORD_BITS-1:0] ox_reg, oy_reg, oz_reg, dx_reg, dy_reg, dz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ox_reg <= '0;
            oy_reg <= '0;
            oz_reg <= '0;
            dx_reg <= COORD_BITS'(ptl_pkg::DIR_X_RESET);
            dy_reg <= '0;
            dz_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (ptl_pkg::cfg_reg_t'(cfg_index))
                ptl_pkg::REG_ORIGIN_X: ox_reg <= cfg_data;
                ptl_pkg::REG_ORIGIN_Y: oy_reg <= cfg_data;
                ptl_pkg::REG_ORIGIN_Z: oz_reg <= cfg_data;
                ptl_pkg::REG_DIR_X:    dx_reg <= cfg_data;
                ptl_pkg::REG_DIR_Y:    dy_reg <= cfg_data;
                ptl_pkg::REG_DIR_Z:    dz_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign origin_x = ox_reg;
    assign origin_y = oy_reg;
    assign origin_z = oz_reg;
    assign dir_x    = dx_reg;
    assign dir_y    = dy_reg;
    assign dir_z    = dz_reg;

endmodule

// ===== design/ptl_front.sv =====
// Front pipeline: offset, cross product, squared lengths and numerator.
// Depends on ptl_pkg for width helpers.
module ptl_front #(
    parameter int COORD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic signed [COORD_BITS-1:0]  point_x,
    input  logic signed [COORD_BITS-1:0]  point_y,
    input  logic signed [COORD_BITS-1:0]  point_z,
    input  logic signed [COORD_BITS-1:0]  origin_x,
    input  logic signed [COORD_BITS-1:0]  origin_y,
    input  logic signed [COORD_BITS-1:0]  origin_z,
    input  logic signed [COORD_BITS-1:0]  dir_x,
    input  logic signed [COORD_BITS-1:0]  dir_y,
    input  logic signed [COORD_BITS-1:0]  dir_z,
    output logic                          out_valid,
    output logic [ptl_pkg::num_width(COORD_BITS)-1:0] num,
    output logic [ptl_pkg::div_width(COORD_BITS)-1:0] divisor,
    output logic                          degen
);

    localparam int C  = COORD_BITS;
    localparam int OW = C + 1;
    localparam int PW = 2 * C + 1;
    localparam int MW = ptl_pkg::mag_width(C);
    localparam int XW = MW + 1;
    localparam int DW = ptl_pkg::div_width(C);
    localparam int NW = ptl_pkg::num_width(C);
    localparam int K  = (MW + 1) / 2;
    localparam int HW = MW - K;
    localparam int SW = 2 * MW;

    logic [ptl_pkg::FRONT_STAGES-1:0] vld_reg;

    logic signed [OW-1:0] ofs_reg  [3];
    logic signed [C-1:0]  dir_reg  [3];
    logic [C-1:0]         dmag_reg [3];

    logic signed [PW-1:0] prod_reg [6];
    logic [DW-1:0]        dsq_reg  [3];
    logic [MW-1:0]        omag_reg [3];

    logic [MW-1:0]        sqop_reg [3];
    logic [DW-1:0]        dvs3_reg, dvs4_reg, dvs5_reg, dvs6_reg;
    logic                 dg3_reg, dg4_reg, dg5_reg, dg6_reg;

    logic [2*HW-1:0]      hh_reg [3];
    logic [HW+K-1:0]      hl_reg [3];
    logic [2*K-1:0]       ll_reg [3];

    logic [SW-1:0]        sq_reg [3];
    logic [NW-1:0]        num_reg;

    logic signed [COORD_BITS-1:0] pnt_w [3];
    logic signed [COORD_BITS-1:0] org_w [3];
    logic signed [COORD_BITS-1:0] dir_w [3];
    logic signed [XW-1:0] cross_w [3];
    logic [MW-1:0]        cmag_w  [3];
    logic [DW-1:0]        dd_w;
    logic                 dzero_w;

    assign pnt_w[0] = point_x;
    assign pnt_w[1] = point_y;
    assign pnt_w[2] = point_z;
    assign org_w[0] = origin_x;
    assign org_w[1] = origin_y;
    assign org_w[2] = origin_z;
    assign dir_w[0] = dir_x;
    assign dir_w[1] = dir_y;
    assign dir_w[2] = dir_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[ptl_pkg::FRONT_STAGES-2:0], in_valid};
        end
    end

    always_comb
    begin
        cross_w[0] = XW'(prod_reg[0]) - XW'(prod_reg[1]);
        cross_w[1] = XW'(prod_reg[2]) - XW'(prod_reg[3]);
        cross_w[2] = XW'(prod_reg[4]) - XW'(prod_reg[5]);
        for (int k = 0; k < 3; k++)
        begin
            cmag_w[k] = cross_w[k][XW-1] ? MW'(-cross_w[k]) : MW'(cross_w[k]);
        end
        dd_w    = dsq_reg[0] + dsq_reg[1] + dsq_reg[2];
        dzero_w = (dd_w == '0);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 3; k++)
        begin
            ofs_reg[k]  <= OW'(pnt_w[k]) - OW'(org_w[k]);
            dir_reg[k]  <= dir_w[k];
            dmag_reg[k] <= dir_w[k][C-1] ? C'(-dir_w[k]) : C'(dir_w[k]);

            dsq_reg[k]  <= DW'(dmag_reg[k]) * DW'(dmag_reg[k]);
            omag_reg[k] <= ofs_reg[k][OW-1] ? MW'(OW'(-ofs_reg[k])) : MW'(OW'(ofs_reg[k]));

            sqop_reg[k] <= dzero_w ? omag_reg[k] : cmag_w[k];

            hh_reg[k] <= (2*HW)'(sqop_reg[k][MW-1:K]) * (2*HW)'(sqop_reg[k][MW-1:K]);
            hl_reg[k] <= (HW+K)'(sqop_reg[k][MW-1:K]) * (HW+K)'(sqop_reg[k][K-1:0]);
            ll_reg[k] <= (2*K)'(sqop_reg[k][K-1:0]) * (2*K)'(sqop_reg[k][K-1:0]);

            sq_reg[k] <= (SW'(hh_reg[k]) << (2 * K)) + (SW'(hl_reg[k]) << (K + 1))
                       + SW'(ll_reg[k]);
        end

        prod_reg[0] <= PW'(ofs_reg[1]) * PW'(dir_reg[2]);
        prod_reg[1] <= PW'(ofs_reg[2]) * PW'(dir_reg[1]);
        prod_reg[2] <= PW'(ofs_reg[2]) * PW'(dir_reg[0]);
        prod_reg[3] <= PW'(ofs_reg[0]) * PW'(dir_reg[2]);
        prod_reg[4] <= PW'(ofs_reg[0]) * PW'(dir_reg[1]);
        prod_reg[5] <= PW'(ofs_reg[1]) * PW'(dir_reg[0]);

        dvs3_reg <= dzero_w ? DW'(1) : dd_w;
        dg3_reg  <= dzero_w;
        dvs4_reg <= dvs3_reg;
        dg4_reg  <= dg3_reg;
        dvs5_reg <= dvs4_reg;
        dg5_reg  <= dg4_reg;
        dvs6_reg <= dvs5_reg;
        dg6_reg  <= dg5_reg;

        num_reg <= NW'(sq_reg[0]) + NW'(sq_reg[1]) + NW'(sq_reg[2]);
    end

    assign out_valid = vld_reg[ptl_pkg::FRONT_STAGES-1];
    assign num       = num_reg;
    assign divisor   = dvs6_reg;
    assign degen     = dg6_reg;

endmodule

// ===== design/ptl_div.sv =====
// Restoring divider, one quotient bit per pipeline stage.
// Depends on ptl_pkg for width helpers.
module ptl_div #(
    parameter int COORD_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      in_valid,
    input  logic [ptl_pkg::num_width(COORD_BITS)-1:0] num,
    input  logic [ptl_pkg::div_width(COORD_BITS)-1:0] divisor,
    input  logic                                      degen_in,
    output logic                                      out_valid,
    output logic [ptl_pkg::quo_width(COORD_BITS)-1:0] quotient,
    output logic                                      degen_out
);

    localparam int NW = ptl_pkg::num_width(COORD_BITS);
    localparam int DW = ptl_pkg::div_width(COORD_BITS);
    localparam int QW = ptl_pkg::quo_width(COORD_BITS);

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [DW-1:0] dvs_reg [QW];
    logic          dg_reg  [QW];
    logic [QW-1:0] vld_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [DW-1:0] dvs_in;
        logic          dg_in;
        logic          vld_in;
        logic [DW:0]   trial;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign rem_in = DW'(num[NW-1:QW]);
            assign low_in = num[QW-1:0];
            assign dvs_in = divisor;
            assign dg_in  = degen_in;
            assign vld_in = in_valid;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[i-1];
            assign low_in = low_reg[i-1];
            assign dvs_in = dvs_reg[i-1];
            assign dg_in  = dg_reg[i-1];
            assign vld_in = vld_reg[i-1];
        end

        assign trial = {rem_in, low_in[QW-1]};
        assign ge    = (trial >= {1'b0, dvs_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i] <= ge ? DW'(trial - {1'b0, dvs_in}) : DW'(trial);
            low_reg[i] <= {low_in[QW-2:0], ge};
            dvs_reg[i] <= dvs_in;
            dg_reg[i]  <= dg_in;
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quotient  = low_reg[QW-1];
    assign degen_out = dg_reg[QW-1];

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[QW-1] |-> (rem_reg[QW-1] < dvs_reg[QW-1]))
        else $error("divider remainder not below divisor");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] |-> (dvs_reg[0] != '0))
        else $error("zero divisor entered divider");

endmodule

// ===== design/ptl_sqrt.sv =====
// Integer square root, one root bit per pipeline stage.
// Depends on ptl_pkg for width helpers.
module ptl_sqrt #(
    parameter int COORD_BITS = 16
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    input  logic [ptl_pkg::quo_width(COORD_BITS)-1:0]  radicand,
    input  logic                                       degen_in,
    output logic                                       out_valid,
    output logic [ptl_pkg::root_width(COORD_BITS)-1:0] root,
    output logic                                       degen_out
);

    localparam int QW = ptl_pkg::quo_width(COORD_BITS);
    localparam int RW = ptl_pkg::root_width(COORD_BITS);
    localparam int EW = RW + 1;

    logic [QW-1:0] val_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [EW-1:0] rem_reg  [RW];
    logic          dg_reg   [RW];
    logic [RW-1:0] vld_reg;

    for (genvar i = 0; i < RW; i++)
    begin : g_stage
        logic [QW-1:0] val_in;
        logic [RW-1:0] root_in;
        logic [EW-1:0] rem_in;
        logic          dg_in;
        logic          vld_in;
        logic [EW+1:0] r4;
        logic [EW+1:0] trial;
        logic          ge;

        if (i == 0)
        begin : g_first
            assign val_in  = radicand;
            assign root_in = '0;
            assign rem_in  = '0;
            assign dg_in   = degen_in;
            assign vld_in  = in_valid;
        end
        else
        begin : g_next
            assign val_in  = val_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign dg_in   = dg_reg[i-1];
            assign vld_in  = vld_reg[i-1];
        end

        assign r4    = {rem_in, val_in[QW-1:QW-2]};
        assign trial = (EW+2)'({root_in, 2'b01});
        assign ge    = (r4 >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[i] <= 1'b0;
            end
            else
            begin
                vld_reg[i] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[i]  <= ge ? EW'(r4 - trial) : EW'(r4);
            root_reg[i] <= {root_in[RW-2:0], ge};
            val_reg[i]  <= {val_in[QW-3:0], 2'b00};
            dg_reg[i]   <= dg_in;
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign degen_out = dg_reg[RW-1];

endmodule

// ===== design/point_to_line_distance_3d.sv =====
// Top level: perpendicular distance from a 3D point to a configured line.
// Depends on ptl_pkg, ptl_cfg, ptl_front, ptl_div and ptl_sqrt.
//
//   channel   ports                                   handshake
//   request   point_x, point_y, point_z               start, busy
//   result    distance, degenerate                    done (one-cycle strobe)
//   config    cfg_index, cfg_data                     cfg_we
//
// One request per cycle; busy stays low. Each request passes through the front
// pipeline, the bit-per-stage divider and square root, and a registered output
// stage that clamps the distance to DIST_MAX.
// Reset clears all valid bits and loads the reset line. No stall exists.
module point_to_line_distance_3d #(
    parameter int COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [COORD_BITS-1:0]        point_x,
    input  logic signed [COORD_BITS-1:0]        point_y,
    input  logic signed [COORD_BITS-1:0]        point_z,
    input  logic                                cfg_we,
    input  logic [ptl_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [COORD_BITS-1:0]               cfg_data,
    output logic                                done,
    output logic [ptl_pkg::DIST_BITS-1:0]       distance,
    output logic                                degenerate
);

    localparam int NW  = ptl_pkg::num_width(COORD_BITS);
    localparam int DW  = ptl_pkg::div_width(COORD_BITS);
    localparam int QW  = ptl_pkg::quo_width(COORD_BITS);
    localparam int RW  = ptl_pkg::root_width(COORD_BITS);
    localparam int XW  = (RW > ptl_pkg::DIST_BITS) ? RW : ptl_pkg::DIST_BITS;
    localparam int LAT = ptl_pkg::FRONT_STAGES + QW + RW + 1;

    logic signed [COORD_BITS-1:0] org_x, org_y, org_z, dir_x, dir_y, dir_z;

    logic          fr_valid, fr_degen;
    logic [NW-1:0] fr_num;
    logic [DW-1:0] fr_div;

    logic          dv_valid, dv_degen;
    logic [QW-1:0] dv_quo;

    logic          sq_valid, sq_degen;
    logic [RW-1:0] sq_root;
    logic [XW-1:0] root_ext;

    logic                          done_reg;
    logic [ptl_pkg::DIST_BITS-1:0] dist_reg;
    logic                          degen_reg;

    assign busy = 1'b0;

    ptl_cfg #(.COORD_BITS(COORD_BITS)) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .origin_x (org_x),
        .origin_y (org_y),
        .origin_z (org_z),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .dir_z    (dir_z)
    );

    ptl_front #(.COORD_BITS(COORD_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .point_x  (point_x),
        .point_y  (point_y),
        .point_z  (point_z),
        .origin_x (org_x),
        .origin_y (org_y),
        .origin_z (org_z),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .dir_z    (dir_z),
        .out_valid(fr_valid),
        .num      (fr_num),
        .divisor  (fr_div),
        .degen    (fr_degen)
    );

    ptl_div #(.COORD_BITS(COORD_BITS)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (fr_valid),
        .num      (fr_num),
        .divisor  (fr_div),
        .degen_in (fr_degen),
        .out_valid(dv_valid),
        .quotient (dv_quo),
        .degen_out(dv_degen)
    );

    ptl_sqrt #(.COORD_BITS(COORD_BITS)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (dv_valid),
        .radicand (dv_quo),
        .degen_in (dv_degen),
        .out_valid(sq_valid),
        .root     (sq_root),
        .degen_out(sq_degen)
    );

    assign root_ext = XW'(sq_root);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= sq_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg  <= (root_ext > XW'(ptl_pkg::DIST_MAX)) ? ptl_pkg::DIST_MAX
                                                         : ptl_pkg::DIST_BITS'(root_ext);
        degen_reg <= sq_degen;
    end

    assign done       = done_reg;
    assign distance   = dist_reg;
    assign degenerate = degen_reg;

    a_request_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LAT done)
        else $error("request produced no result");

    a_result_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result without matching request");

endmodule
